// ===== rtl/bpvm_pkg.sv =====
// Shared types, constants and a helper for the battery pack voltage monitor.
// Used by bpvm_div.sv, battery_pack_voltage_monitor.sv and the testbench; no dependencies.
package bpvm_pkg;

  localparam int unsigned MAX_CELL_COUNT = 8;
  localparam int unsigned CELL_W = 4;
  localparam int unsigned MV_W = 16;
  localparam int unsigned CELL_MV_W = 13;
  localparam int unsigned HYST_W = 10;
  localparam int unsigned PCT_W = 7;
  localparam int unsigned CFG_IDX_W = 3;

  localparam int unsigned DIVIDEND_W = 20;
  localparam int unsigned DIVISOR_W = 13;
  localparam int unsigned DIV_STEPS = DIVIDEND_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [CELL_MV_W-1:0] NOMINAL_RST = CELL_MV_W'(3700);
  localparam logic [CELL_MV_W-1:0] FULL_RST = CELL_MV_W'(4200);
  localparam logic [CELL_MV_W-1:0] LOW_RST = CELL_MV_W'(3500);
  localparam logic [CELL_MV_W-1:0] CRIT_RST = CELL_MV_W'(3300);
  localparam logic [HYST_W-1:0] HYST_RST = HYST_W'(100);
  localparam logic [MV_W-1:0] DETECT_RST = MV_W'(2500);
  localparam logic [CELL_W-1:0] MANUAL_RST = '0;
  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NOMINAL,
    REG_FULL,
    REG_LOW,
    REG_CRIT,
    REG_HYST,
    REG_DETECT,
    REG_MANUAL
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DETECT,
    S_SPLIT,
    S_EVAL,
    S_PCT,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  function automatic logic [CELL_W-1:0] clamp_cells(input logic [DIVIDEND_W-1:0] n);
    logic [CELL_W-1:0] r;
    if (n == '0) begin
      r = CELL_W'(1);
    end else if (n > DIVIDEND_W'(MAX_CELL_COUNT)) begin
      r = CELL_W'(MAX_CELL_COUNT);
    end else begin
      r = n[CELL_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/bpvm_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on bpvm_pkg for widths and the status struct.
module bpvm_div (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [bpvm_pkg::DIVIDEND_W-1:0]     dividend_i,
  input  logic [bpvm_pkg::DIVISOR_W-1:0]      divisor_i,
  output bpvm_pkg::div_stat_t                 stat_o,
  output logic [bpvm_pkg::DIVIDEND_W-1:0]     quotient_o
);

  logic [bpvm_pkg::DIVIDEND_W-1:0] acc_q, acc_d;
  logic [bpvm_pkg::DIVISOR_W-1:0]  rem_q, rem_d;
  logic [bpvm_pkg::DIVISOR_W-1:0]  dsr_q, dsr_d;
  logic [bpvm_pkg::DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic                            busy_q, busy_d;
  logic                            done_q, done_d;
  logic [bpvm_pkg::DIVISOR_W:0]    trial;
  logic [bpvm_pkg::DIVISOR_W:0]    diff;

  always_comb begin
    trial = {rem_q, acc_q[bpvm_pkg::DIVIDEND_W-1]};
    diff = trial - {1'b0, dsr_q};
    acc_d = acc_q;
    rem_d = rem_q;
    dsr_d = dsr_q;
    cnt_d = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
      cnt_d = bpvm_pkg::DIV_CNT_W'(bpvm_pkg::DIV_STEPS - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = diff[bpvm_pkg::DIVISOR_W-1:0];
        acc_d = {acc_q[bpvm_pkg::DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_d = trial[bpvm_pkg::DIVISOR_W-1:0];
        acc_d = {acc_q[bpvm_pkg::DIVIDEND_W-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o = acc_q;

endmodule

// ===== rtl/battery_pack_voltage_monitor.sv =====
// Top level of the battery pack voltage monitor: configuration, sequencer, result register.
// Depends on bpvm_pkg and bpvm_div.
//
// Usage:
// The input channel carries one pack voltage sample per transfer on pack_mv_i, with
// in_valid_i and in_ready_o. The output channel gives one result per sample, with
// out_valid_o and out_ready_i. Registers are written through cfg_we_i, cfg_idx_i and
// cfg_data_i while the block is idle; any write to a listed register clears both
// latches and restarts cell detection unless a manual count is set.
// Each sample with a cell count runs through one shared bit-serial divider. A result
// comes straight from the finish state while the cell count is unknown; with a known
// count the divider first splits the pack voltage per cell, then gives the charge
// percentage when it lies between the end points, and a detection division runs first
// when detection runs on the sample. One sample is in work at a time, and the next is
// taken only once the sequencer is back in idle after the result register loads.
// Reset restores all registers to their defaults, clears the count and the latches and
// empties the result register. A new sample is taken while a result still waits; if
// the receiver stalls, the next result holds in the sequencer until the result
// register frees, and no further sample is taken meanwhile.
module battery_pack_voltage_monitor (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bpvm_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bpvm_pkg::MV_W-1:0]            cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [bpvm_pkg::MV_W-1:0]            pack_mv_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [bpvm_pkg::CELL_W-1:0]          cells_o,
  output logic [bpvm_pkg::MV_W-1:0]            per_cell_mv_o,
  output logic                                 low_latched_o,
  output logic                                 critical_latched_o,
  output logic                                 low_event_o,
  output logic                                 critical_event_o,
  output logic                                 below_low_now_o,
  output logic                                 below_critical_now_o,
  output logic [bpvm_pkg::PCT_W-1:0]           charge_percent_o
);

  localparam int unsigned CMW = bpvm_pkg::CELL_MV_W;
  localparam int unsigned MVW = bpvm_pkg::MV_W;
  localparam int unsigned DVW = bpvm_pkg::DIVIDEND_W;
  localparam int unsigned DSW = bpvm_pkg::DIVISOR_W;
  localparam int unsigned CW = bpvm_pkg::CELL_W;
  localparam int unsigned PW = bpvm_pkg::PCT_W;

  bpvm_pkg::state_e state_q, state_d;

  logic [CMW-1:0] nominal_q, nominal_d, full_q, full_d, low_q, low_d, crit_q, crit_d;
  logic [bpvm_pkg::HYST_W-1:0] hyst_q, hyst_d;
  logic [MVW-1:0] detect_q, detect_d;
  logic [CW-1:0]  manual_q, manual_d;

  logic [CW-1:0]  cells_q, cells_d;
  logic           locked_q, locked_d;
  logic           low_lat_q, low_lat_d, crit_lat_q, crit_lat_d;

  logic [MVW-1:0] pack_q, pack_d;
  logic [MVW-1:0] per_cell_q, per_cell_d;
  logic           ev_low_q, ev_low_d, ev_crit_q, ev_crit_d;
  logic           now_low_q, now_low_d, now_crit_q, now_crit_d;
  logic [PW-1:0]  pct_q, pct_d;

  logic           out_valid_q, out_valid_d;
  logic [CW-1:0]  o_cells_q, o_cells_d;
  logic [MVW-1:0] o_per_cell_q, o_per_cell_d;
  logic           o_low_lat_q, o_low_lat_d, o_crit_lat_q, o_crit_lat_d;
  logic           o_ev_low_q, o_ev_low_d, o_ev_crit_q, o_ev_crit_d;
  logic           o_now_low_q, o_now_low_d, o_now_crit_q, o_now_crit_d;
  logic [PW-1:0]  o_pct_q, o_pct_d;

  logic           div_start;
  logic [DVW-1:0] div_dividend;
  logic [DSW-1:0] div_divisor;
  logic [DVW-1:0] div_quot;
  bpvm_pkg::div_stat_t div_stat;

  logic           in_accept;
  logic [CMW-1:0] nom_eff;
  logic [CW-1:0]  det_cells;
  logic [CMW-1:0] pct_diff;
  logic [DVW-1:0] pct_num;
  logic [CMW:0]   low_rel, crit_rel;
  logic           cfg_hit;
  logic [CW-1:0]  manual_new;

  bpvm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quotient_o (div_quot)
  );

  always_comb begin
    nom_eff = (nominal_q == '0) ? CMW'(1) : nominal_q;
    det_cells = bpvm_pkg::clamp_cells(div_quot);
    pct_diff = per_cell_q[CMW-1:0] - crit_q;
    pct_num = {1'b0, pct_diff, 6'b0} + {2'b0, pct_diff, 5'b0} + {5'b0, pct_diff, 2'b0};
    low_rel = {1'b0, low_q} + {4'b0, hyst_q};
    crit_rel = {1'b0, crit_q} + {4'b0, hyst_q};
    in_ready_o = (state_q == bpvm_pkg::S_IDLE);
    in_accept = in_valid_i && in_ready_o;

    state_d = state_q;
    div_start = 1'b0;
    div_dividend = {{(DVW-MVW){1'b0}}, pack_q};
    div_divisor = {{(DSW-CW){1'b0}}, cells_q};
    nominal_d = nominal_q;
    full_d = full_q;
    low_d = low_q;
    crit_d = crit_q;
    hyst_d = hyst_q;
    detect_d = detect_q;
    manual_d = manual_q;
    cells_d = cells_q;
    locked_d = locked_q;
    low_lat_d = low_lat_q;
    crit_lat_d = crit_lat_q;
    pack_d = pack_q;
    per_cell_d = per_cell_q;
    ev_low_d = ev_low_q;
    ev_crit_d = ev_crit_q;
    now_low_d = now_low_q;
    now_crit_d = now_crit_q;
    pct_d = pct_q;
    out_valid_d = out_valid_q && !out_ready_i;
    o_cells_d = o_cells_q;
    o_per_cell_d = o_per_cell_q;
    o_low_lat_d = o_low_lat_q;
    o_crit_lat_d = o_crit_lat_q;
    o_ev_low_d = o_ev_low_q;
    o_ev_crit_d = o_ev_crit_q;
    o_now_low_d = o_now_low_q;
    o_now_crit_d = o_now_crit_q;
    o_pct_d = o_pct_q;

    unique case (state_q)
      bpvm_pkg::S_IDLE: begin
        if (in_accept) begin
          pack_d = pack_mv_i;
          per_cell_d = '0;
          ev_low_d = 1'b0;
          ev_crit_d = 1'b0;
          now_low_d = 1'b0;
          now_crit_d = 1'b0;
          pct_d = '0;
          if (!locked_q && (pack_mv_i >= detect_q)) begin
            div_start = 1'b1;
            div_dividend = DVW'({1'b0, pack_mv_i} + {5'b0, nom_eff[CMW-1:1]});
            div_divisor = nom_eff;
            state_d = bpvm_pkg::S_DETECT;
          end else if (cells_q != '0) begin
            div_start = 1'b1;
            div_dividend = {{(DVW-MVW){1'b0}}, pack_mv_i};
            div_divisor = {{(DSW-CW){1'b0}}, cells_q};
            state_d = bpvm_pkg::S_SPLIT;
          end else begin
            state_d = bpvm_pkg::S_FINISH;
          end
        end
      end
      bpvm_pkg::S_DETECT: begin
        if (div_stat.done) begin
          cells_d = det_cells;
          locked_d = 1'b1;
          div_start = 1'b1;
          div_divisor = {{(DSW-CW){1'b0}}, det_cells};
          state_d = bpvm_pkg::S_SPLIT;
        end
      end
      bpvm_pkg::S_SPLIT: begin
        if (div_stat.done) begin
          per_cell_d = div_quot[MVW-1:0];
          state_d = bpvm_pkg::S_EVAL;
        end
      end
      bpvm_pkg::S_EVAL: begin
        now_low_d = per_cell_q <= {3'b0, low_q};
        now_crit_d = per_cell_q <= {3'b0, crit_q};
        if (!low_lat_q && now_low_d) begin
          low_lat_d = 1'b1;
          ev_low_d = 1'b1;
        end else if (low_lat_q && (per_cell_q > {2'b0, low_rel})) begin
          low_lat_d = 1'b0;
        end
        if (!crit_lat_q && now_crit_d) begin
          crit_lat_d = 1'b1;
          ev_crit_d = 1'b1;
        end else if (crit_lat_q && (per_cell_q > {2'b0, crit_rel})) begin
          crit_lat_d = 1'b0;
        end
        if (per_cell_q >= {3'b0, full_q}) begin
          pct_d = bpvm_pkg::PCT_FULL;
          state_d = bpvm_pkg::S_FINISH;
        end else if (now_crit_d) begin
          pct_d = '0;
          state_d = bpvm_pkg::S_FINISH;
        end else begin
          div_start = 1'b1;
          div_dividend = pct_num;
          div_divisor = full_q - crit_q;
          state_d = bpvm_pkg::S_PCT;
        end
      end
      bpvm_pkg::S_PCT: begin
        if (div_stat.done) begin
          pct_d = div_quot[PW-1:0];
          state_d = bpvm_pkg::S_FINISH;
        end
      end
      bpvm_pkg::S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          o_cells_d = cells_q;
          o_per_cell_d = per_cell_q;
          o_low_lat_d = low_lat_q;
          o_crit_lat_d = crit_lat_q;
          o_ev_low_d = ev_low_q;
          o_ev_crit_d = ev_crit_q;
          o_now_low_d = now_low_q;
          o_now_crit_d = now_crit_q;
          o_pct_d = pct_q;
          state_d = bpvm_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = bpvm_pkg::S_IDLE;
      end
    endcase

    // Writes are to arrive only while the block is idle (the block does not enforce it); they take priority here.
    cfg_hit = cfg_we_i && (cfg_idx_i <= bpvm_pkg::REG_MANUAL);
    manual_new = (cfg_idx_i == bpvm_pkg::REG_MANUAL) ? cfg_data_i[CW-1:0] : manual_q;
    if (cfg_hit) begin
      unique case (cfg_idx_i)
        bpvm_pkg::REG_NOMINAL: nominal_d = cfg_data_i[CMW-1:0];
        bpvm_pkg::REG_FULL:    full_d = cfg_data_i[CMW-1:0];
        bpvm_pkg::REG_LOW:     low_d = cfg_data_i[CMW-1:0];
        bpvm_pkg::REG_CRIT:    crit_d = cfg_data_i[CMW-1:0];
        bpvm_pkg::REG_HYST:    hyst_d = cfg_data_i[bpvm_pkg::HYST_W-1:0];
        bpvm_pkg::REG_DETECT:  detect_d = cfg_data_i;
        default:               manual_d = cfg_data_i[CW-1:0];
      endcase
      low_lat_d = 1'b0;
      crit_lat_d = 1'b0;
      if (manual_new != '0) begin
        cells_d = bpvm_pkg::clamp_cells({{(DVW-CW){1'b0}}, manual_new});
        locked_d = 1'b1;
      end else begin
        cells_d = '0;
        locked_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bpvm_pkg::S_IDLE;
      nominal_q <= bpvm_pkg::NOMINAL_RST;
      full_q <= bpvm_pkg::FULL_RST;
      low_q <= bpvm_pkg::LOW_RST;
      crit_q <= bpvm_pkg::CRIT_RST;
      hyst_q <= bpvm_pkg::HYST_RST;
      detect_q <= bpvm_pkg::DETECT_RST;
      manual_q <= bpvm_pkg::MANUAL_RST;
      cells_q <= '0;
      locked_q <= 1'b0;
      low_lat_q <= 1'b0;
      crit_lat_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      nominal_q <= nominal_d;
      full_q <= full_d;
      low_q <= low_d;
      crit_q <= crit_d;
      hyst_q <= hyst_d;
      detect_q <= detect_d;
      manual_q <= manual_d;
      cells_q <= cells_d;
      locked_q <= locked_d;
      low_lat_q <= low_lat_d;
      crit_lat_q <= crit_lat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pack_q <= pack_d;
    per_cell_q <= per_cell_d;
    ev_low_q <= ev_low_d;
    ev_crit_q <= ev_crit_d;
    now_low_q <= now_low_d;
    now_crit_q <= now_crit_d;
    pct_q <= pct_d;
    o_cells_q <= o_cells_d;
    o_per_cell_q <= o_per_cell_d;
    o_low_lat_q <= o_low_lat_d;
    o_crit_lat_q <= o_crit_lat_d;
    o_ev_low_q <= o_ev_low_d;
    o_ev_crit_q <= o_ev_crit_d;
    o_now_low_q <= o_now_low_d;
    o_now_crit_q <= o_now_crit_d;
    o_pct_q <= o_pct_d;
  end

  assign out_valid_o = out_valid_q;
  assign cells_o = o_cells_q;
  assign per_cell_mv_o = o_per_cell_q;
  assign low_latched_o = o_low_lat_q;
  assign critical_latched_o = o_crit_lat_q;
  assign low_event_o = o_ev_low_q;
  assign critical_event_o = o_ev_crit_q;
  assign below_low_now_o = o_now_low_q;
  assign below_critical_now_o = o_now_crit_q;
  assign charge_percent_o = o_pct_q;

`ifndef SYNTH
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_event_sets_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (low_event_o || critical_event_o) |->
      (!low_event_o || low_latched_o) && (!critical_event_o || critical_latched_o))
    else $error("event without its latch");

  a_no_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (cells_o == '0) |-> (per_cell_mv_o == '0) && (charge_percent_o == '0))
    else $error("result fields nonzero without a cell count");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> charge_percent_o <= bpvm_pkg::PCT_FULL)
    else $error("charge percentage out of range");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for battery_pack_voltage_monitor: a directed stimulus table, then
// random configuration phases with bursty samples and a stalling receiver. Depends on bpvm_pkg
// and the RTL; results are predicted in-line or fixed by the table, and checked field by field.
module testbench;

  localparam logic [bpvm_pkg::CFG_IDX_W-1:0] REG_UNLISTED = bpvm_pkg::CFG_IDX_W'(7);
  localparam int unsigned REG_COUNT = int'(bpvm_pkg::REG_MANUAL) + 1;
  localparam int unsigned IDLE_LIMIT = 4000;
  localparam int unsigned TARGET_SAMPLES = 1000;
  localparam int unsigned HOLD_AFTER = 300;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned DRAIN_CYCLES = 100;

  typedef struct packed {
    logic [bpvm_pkg::CELL_W-1:0] cells;
    logic [bpvm_pkg::MV_W-1:0]   per_cell;
    logic                        low_latched;
    logic                        crit_latched;
    logic                        low_event;
    logic                        crit_event;
    logic                        low_now;
    logic                        crit_now;
    logic [bpvm_pkg::PCT_W-1:0]  pct;
  } reading_t;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct {
    row_kind_e                       kind;
    logic [bpvm_pkg::CFG_IDX_W-1:0]  idx;
    logic [bpvm_pkg::MV_W-1:0]       value;
    bit                              fixed;
    reading_t                        want;
  } row_t;

  localparam reading_t EIGHT_AT_TOP = '{cells: bpvm_pkg::CELL_W'(8),
    per_cell: bpvm_pkg::MV_W'(8191),
    low_latched: 1'b0, crit_latched: 1'b0, low_event: 1'b0, crit_event: 1'b0,
    low_now: 1'b0, crit_now: 1'b0, pct: bpvm_pkg::PCT_W'(100)};
  localparam reading_t EIGHT_AT_ZERO = '{cells: bpvm_pkg::CELL_W'(8),
    per_cell: bpvm_pkg::MV_W'(0),
    low_latched: 1'b1, crit_latched: 1'b1, low_event: 1'b1, crit_event: 1'b1,
    low_now: 1'b1, crit_now: 1'b1, pct: bpvm_pkg::PCT_W'(0)};
  localparam reading_t NO_COUNT = '0;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           cfg_we_i = 1'b0;
  logic [bpvm_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [bpvm_pkg::MV_W-1:0]      cfg_data_i = '0;
  logic                           in_valid_i = 1'b0;
  logic                           in_ready_o;
  logic [bpvm_pkg::MV_W-1:0]      pack_mv_i = '0;
  logic                           out_valid_o;
  logic                           out_ready_i = 1'b0;
  logic [bpvm_pkg::CELL_W-1:0]    cells_o;
  logic [bpvm_pkg::MV_W-1:0]      per_cell_mv_o;
  logic                           low_latched_o;
  logic                           critical_latched_o;
  logic                           low_event_o;
  logic                           critical_event_o;
  logic                           below_low_now_o;
  logic                           below_critical_now_o;
  logic [bpvm_pkg::PCT_W-1:0]     charge_percent_o;

  battery_pack_voltage_monitor dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_we_i             (cfg_we_i),
    .cfg_idx_i            (cfg_idx_i),
    .cfg_data_i           (cfg_data_i),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .pack_mv_i            (pack_mv_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .cells_o              (cells_o),
    .per_cell_mv_o        (per_cell_mv_o),
    .low_latched_o        (low_latched_o),
    .critical_latched_o   (critical_latched_o),
    .low_event_o          (low_event_o),
    .critical_event_o     (critical_event_o),
    .below_low_now_o      (below_low_now_o),
    .below_critical_now_o (below_critical_now_o),
    .charge_percent_o     (charge_percent_o)
  );

  // Monitor settings and state as the block should hold them.
  logic [bpvm_pkg::CELL_MV_W-1:0] nom_cell_mv, full_mv, low_mv, crit_mv;
  logic [bpvm_pkg::HYST_W-1:0]    hyst_mv;
  logic [bpvm_pkg::MV_W-1:0]      detect_mv;
  logic [bpvm_pkg::CELL_W-1:0]    manual_count, cell_count;
  bit                             count_locked, low_latch, crit_latch;

  reading_t    pending_readings[$];
  row_t        directed_rows[$];
  reading_t    seen_reading;
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  bit          sending = 1'b0;
  bit          writing = 1'b0;

  assign seen_reading = {cells_o, per_cell_mv_o, low_latched_o, critical_latched_o,
                         low_event_o, critical_event_o, below_low_now_o,
                         below_critical_now_o, charge_percent_o};

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned bound_cells(int unsigned n);
    if (n < 1) return 1;
    if (n > bpvm_pkg::MAX_CELL_COUNT) return bpvm_pkg::MAX_CELL_COUNT;
    return n;
  endfunction

  function automatic void store_register(logic [bpvm_pkg::CFG_IDX_W-1:0] idx,
                                         logic [bpvm_pkg::MV_W-1:0] data);
    case (idx)
      bpvm_pkg::REG_NOMINAL: nom_cell_mv = data[bpvm_pkg::CELL_MV_W-1:0];
      bpvm_pkg::REG_FULL:    full_mv = data[bpvm_pkg::CELL_MV_W-1:0];
      bpvm_pkg::REG_LOW:     low_mv = data[bpvm_pkg::CELL_MV_W-1:0];
      bpvm_pkg::REG_CRIT:    crit_mv = data[bpvm_pkg::CELL_MV_W-1:0];
      bpvm_pkg::REG_HYST:    hyst_mv = data[bpvm_pkg::HYST_W-1:0];
      bpvm_pkg::REG_DETECT:  detect_mv = data;
      bpvm_pkg::REG_MANUAL:  manual_count = data[bpvm_pkg::CELL_W-1:0];
      default:               return;
    endcase
    low_latch = 1'b0;
    crit_latch = 1'b0;
    if (manual_count != 0) begin
      cell_count = bpvm_pkg::CELL_W'(bound_cells(manual_count));
      count_locked = 1'b1;
    end else begin
      cell_count = '0;
      count_locked = 1'b0;
    end
  endfunction

  function automatic reading_t predict_reading(logic [bpvm_pkg::MV_W-1:0] pack);
    reading_t    r;
    int unsigned nom, per;
    r = '0;
    if (!count_locked && pack >= detect_mv) begin
      nom = (nom_cell_mv == 0) ? 1 : nom_cell_mv;
      cell_count = bpvm_pkg::CELL_W'(bound_cells((pack + nom / 2) / nom));
      count_locked = 1'b1;
    end
    r.cells = cell_count;
    if (cell_count != 0) begin
      per = pack / cell_count;
      r.per_cell = bpvm_pkg::MV_W'(per);
      r.low_now = (per <= low_mv);
      r.crit_now = (per <= crit_mv);
      if (!low_latch && r.low_now) begin
        low_latch = 1'b1;
        r.low_event = 1'b1;
      end else if (low_latch && per > low_mv + hyst_mv) begin
        low_latch = 1'b0;
      end
      if (!crit_latch && r.crit_now) begin
        crit_latch = 1'b1;
        r.crit_event = 1'b1;
      end else if (crit_latch && per > crit_mv + hyst_mv) begin
        crit_latch = 1'b0;
      end
      if (per >= full_mv) begin
        r.pct = bpvm_pkg::PCT_W'(100);
      end else if (per <= crit_mv) begin
        r.pct = '0;
      end else begin
        r.pct = bpvm_pkg::PCT_W'((per - crit_mv) * 100 / (full_mv - crit_mv));
      end
    end
    r.low_latched = low_latch;
    r.crit_latched = crit_latch;
    return r;
  endfunction

  function automatic logic [bpvm_pkg::MV_W-1:0] pick_setting(
      logic [bpvm_pkg::CFG_IDX_W-1:0] idx, bit wild);
    if (wild) begin
      case ($urandom_range(0, 3))
        0:       return '0;
        1:       return '1;
        2:       return bpvm_pkg::MV_W'($urandom_range(0, 65535));
        default: ;
      endcase
    end
    case (idx)
      bpvm_pkg::REG_NOMINAL: return bpvm_pkg::MV_W'($urandom_range(3000, 4200));
      bpvm_pkg::REG_FULL:    return bpvm_pkg::MV_W'($urandom_range(3900, 4500));
      bpvm_pkg::REG_LOW:     return bpvm_pkg::MV_W'($urandom_range(3300, 3700));
      bpvm_pkg::REG_CRIT:    return bpvm_pkg::MV_W'($urandom_range(2800, 3400));
      bpvm_pkg::REG_HYST:    return bpvm_pkg::MV_W'($urandom_range(0, 300));
      bpvm_pkg::REG_DETECT:  return bpvm_pkg::MV_W'($urandom_range(0, 12000));
      bpvm_pkg::REG_MANUAL:  return ($urandom_range(0, 2) == 0) ?
          bpvm_pkg::MV_W'($urandom_range(1, bpvm_pkg::MAX_CELL_COUNT)) : '0;
      default:               return bpvm_pkg::MV_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // Most samples sit near a threshold, its release point or the full point.
  function automatic logic [bpvm_pkg::MV_W-1:0] pick_pack();
    int unsigned n, base, v;
    case ($urandom_range(0, 9))
      0, 1: return bpvm_pkg::MV_W'($urandom_range(0, 65535));
      2: begin
        case ($urandom_range(0, 3))
          0:       return '0;
          1:       return '1;
          2:       return detect_mv;
          default: return detect_mv - 1'b1;
        endcase
      end
      default: begin
        n = (cell_count != 0) ? cell_count : $urandom_range(1, bpvm_pkg::MAX_CELL_COUNT);
        case ($urandom_range(0, 5))
          0:       base = low_mv;
          1:       base = crit_mv;
          2:       base = full_mv;
          3:       base = low_mv + hyst_mv;
          4:       base = crit_mv + hyst_mv;
          default: base = nom_cell_mv;
        endcase
        base = base + $urandom_range(0, 24);
        base = (base > 12) ? base - 12 : 0;
        v = base * n + $urandom_range(0, n - 1);
        return (v > 65535) ? '1 : bpvm_pkg::MV_W'(v);
      end
    endcase
  endfunction

  function automatic void add_write(logic [bpvm_pkg::CFG_IDX_W-1:0] idx,
                                    logic [bpvm_pkg::MV_W-1:0] data);
    row_t r;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.value = data;
    r.fixed = 1'b0;
    r.want = '0;
    directed_rows.push_back(r);
  endfunction

  function automatic void add_sample(logic [bpvm_pkg::MV_W-1:0] pack, bit fixed,
                                     reading_t want);
    row_t r;
    r.kind = ROW_SAMPLE;
    r.idx = '0;
    r.value = pack;
    r.fixed = fixed;
    r.want = want;
    directed_rows.push_back(r);
  endfunction

  task automatic report(string what, int unsigned got, int unsigned want);
    $display("%0t: %s mismatch, got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  task automatic check_reading(reading_t got, reading_t want);
    if (got.cells !== want.cells) report("cells", got.cells, want.cells);
    if (got.per_cell !== want.per_cell) report("per_cell_mv", got.per_cell, want.per_cell);
    if (got.low_latched !== want.low_latched) begin
      report("low_latched", got.low_latched, want.low_latched);
    end
    if (got.crit_latched !== want.crit_latched) begin
      report("critical_latched", got.crit_latched, want.crit_latched);
    end
    if (got.low_event !== want.low_event) report("low_event", got.low_event, want.low_event);
    if (got.crit_event !== want.crit_event) begin
      report("critical_event", got.crit_event, want.crit_event);
    end
    if (got.low_now !== want.low_now) report("below_low_now", got.low_now, want.low_now);
    if (got.crit_now !== want.crit_now) begin
      report("below_critical_now", got.crit_now, want.crit_now);
    end
    if (got.pct !== want.pct) report("charge_percent", got.pct, want.pct);
  endtask

  // Drop valid if it is up, then wait until every expected result has arrived.
  task automatic settle();
    if (sending) begin
      in_valid_i <= 1'b0;
      sending = 1'b0;
      @(posedge clk_i);
    end
    while (pending_readings.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [bpvm_pkg::CFG_IDX_W-1:0] idx,
                           logic [bpvm_pkg::MV_W-1:0] data);
    settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    writing = 1'b1;
    @(posedge clk_i);
    store_register(idx, data);
  endtask

  task automatic offer(logic [bpvm_pkg::MV_W-1:0] pack, bit fixed, reading_t want);
    reading_t r;
    if (writing) begin
      cfg_we_i <= 1'b0;
      writing = 1'b0;
    end
    in_valid_i <= 1'b1;
    pack_mv_i <= pack;
    sending = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    r = predict_reading(pack);
    pending_readings.push_back(fixed ? want : r);
  endtask

  task automatic pause(int unsigned cycles);
    if (sending) begin
      in_valid_i <= 1'b0;
      sending = 1'b0;
    end
    if (writing) begin
      cfg_we_i <= 1'b0;
      writing = 1'b0;
    end
    repeat (cycles) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned                    sent, phase_len, burst_left, k, start;
    bit                             wild;
    logic [bpvm_pkg::CFG_IDX_W-1:0] idx;

    nom_cell_mv = bpvm_pkg::NOMINAL_RST;
    full_mv = bpvm_pkg::FULL_RST;
    low_mv = bpvm_pkg::LOW_RST;
    crit_mv = bpvm_pkg::CRIT_RST;
    hyst_mv = bpvm_pkg::HYST_RST;
    detect_mv = bpvm_pkg::DETECT_RST;
    manual_count = bpvm_pkg::MANUAL_RST;
    cell_count = '0;
    count_locked = 1'b0;
    low_latch = 1'b0;
    crit_latch = 1'b0;

    // Default settings first: no count below the detect minimum, then detection at four cells
    // and walks through both latches and their release points.
    add_sample(16'd0, 1'b1, NO_COUNT);
    add_sample(16'd2499, 1'b1, NO_COUNT);
    add_sample(16'd14800, 1'b0, NO_COUNT);
    add_sample(16'd65535, 1'b0, NO_COUNT);
    add_sample(16'd13000, 1'b0, NO_COUNT);
    add_sample(16'd13000, 1'b0, NO_COUNT);
    add_sample(16'd14400, 1'b0, NO_COUNT);
    add_sample(16'd14404, 1'b0, NO_COUNT);
    add_sample(16'd13200, 1'b0, NO_COUNT);
    add_write(REG_UNLISTED, 16'hFFFF);
    add_sample(16'd13204, 1'b0, NO_COUNT);
    // A manual count above the maximum is clamped.
    add_write(bpvm_pkg::REG_MANUAL, 16'hFFFF);
    add_sample(16'd0, 1'b1, EIGHT_AT_ZERO);
    // Zero nominal voltage counts as one millivolt, so detection clamps high.
    add_write(bpvm_pkg::REG_MANUAL, 16'd0);
    add_write(bpvm_pkg::REG_NOMINAL, 16'd0);
    add_write(bpvm_pkg::REG_DETECT, 16'd0);
    add_sample(16'd65535, 1'b1, EIGHT_AT_TOP);
    add_write(bpvm_pkg::REG_NOMINAL, 16'hFFFF);
    add_write(bpvm_pkg::REG_DETECT, 16'hFFFF);
    add_sample(16'd65534, 1'b1, NO_COUNT);
    add_sample(16'd65535, 1'b1, EIGHT_AT_TOP);
    // Detection that rounds down to zero cells still yields one.
    add_write(bpvm_pkg::REG_NOMINAL, 16'd5000);
    add_write(bpvm_pkg::REG_DETECT, 16'd1);
    add_sample(16'd0, 1'b1, NO_COUNT);
    add_sample(16'd1, 1'b0, NO_COUNT);
    // Full point below the critical point, with oversized threshold and hysteresis writes.
    add_write(bpvm_pkg::REG_FULL, 16'd3000);
    add_write(bpvm_pkg::REG_CRIT, 16'd3300);
    add_write(bpvm_pkg::REG_HYST, 16'hFFFF);
    add_write(bpvm_pkg::REG_LOW, 16'hFFFF);
    add_write(bpvm_pkg::REG_MANUAL, 16'd1);
    add_sample(16'd3100, 1'b0, NO_COUNT);
    add_sample(16'd2999, 1'b0, NO_COUNT);
    add_sample(16'd3000, 1'b0, NO_COUNT);
    add_sample(16'd65535, 1'b0, NO_COUNT);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        write_reg(directed_rows[i].idx, directed_rows[i].value);
      end else begin
        offer(directed_rows[i].value, directed_rows[i].fixed, directed_rows[i].want);
      end
    end

    sent = 0;
    while (sent < TARGET_SAMPLES) begin
      wild = ($urandom_range(0, 3) == 0);
      start = $urandom_range(0, REG_COUNT - 1);
      for (k = 0; k < REG_COUNT; k++) begin
        idx = bpvm_pkg::CFG_IDX_W'((start + k) % REG_COUNT);
        write_reg(idx, pick_setting(idx, wild && ($urandom_range(0, 1) == 1)));
      end
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_UNLISTED, bpvm_pkg::MV_W'($urandom_range(0, 65535)));
      end
      phase_len = $urandom_range(30, 70);
      burst_left = $urandom_range(1, 20);
      for (k = 0; k < phase_len; k++) begin
        offer(pick_pack(), 1'b0, NO_COUNT);
        sent++;
        burst_left--;
        if (burst_left == 0) begin
          if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
          burst_left = ($urandom_range(0, 4) == 0) ? 200 : $urandom_range(1, 20);
        end
      end
    end

    pause(1);
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // The receiver switches between patterns and, once, holds off long enough to back up the
  // block while samples keep coming.
  initial begin : receiver
    int unsigned mode, span;
    bit          held;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 150);
      repeat (span) begin
        @(posedge clk_i);
        if (!held && results_seen >= HOLD_AFTER) begin
          held = 1'b1;
          out_ready_i <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk_i);
        end
        case (mode)
          0:       out_ready_i <= 1'b1;
          1:       out_ready_i <= ($urandom_range(0, 1) == 1);
          2:       out_ready_i <= ($urandom_range(0, 4) == 0);
          default: out_ready_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_readings.size() == 0) begin
        report("unexpected result", seen_reading.per_cell, 0);
      end else begin
        check_reading(seen_reading, pending_readings.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== battery_pack_voltage_monitor.f =====
rtl/bpvm_pkg.sv
rtl/bpvm_div.sv
rtl/battery_pack_voltage_monitor.sv
dv/testbench.sv
